/* hw/rtl/rational_arithmetic_unit_core_macros.svh */
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`ifndef SYNTH
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons)
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/rau_pkg.sv */
// Package: types and constants of the rational arithmetic unit.
package rau_pkg;
   localparam int DEF_WIDTH = 32;
   localparam int NUM_W = 32;
   localparam int DEN_W = 31;
   localparam int OP_W = 3;
   localparam int WIDE_W = 64;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
      OP_DIV = 3'd3, OP_INV = 3'd4, OP_RED = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ALU_MUL = 2'd0, ALU_SUB = 2'd1, ALU_ADD = 2'd2
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_COMB, ST_SIGN,
      ST_GCD, ST_DIVA, ST_DIVB, ST_CHECK, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic divide;
   } div_ctl_type;
endpackage

/* hw/rtl/rau_gcd.sv */
// Binary gcd unit: one subtract and shift step per cycle on 64-bit magnitudes.
module rau_gcd import rau_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] a_val,
   input  logic [WIDE_W-1:0] b_val,
   output logic              done,
   output logic [WIDE_W-1:0] gcd_val
);
   logic [WIDE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [6:0] k_ff, k_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      a_in = a_ff; b_in = b_ff; k_in = k_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         a_in = a_val; b_in = b_val; k_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0; done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1; b_in = b_ff >> 1; k_in = k_ff + 7'd1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = b_ff; b_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      a_ff <= a_in; b_ff <= b_in; k_ff <= k_in;
   end

   assign done = done_ff;
   assign gcd_val = a_ff << k_ff[5:0];
endmodule

/* hw/rtl/rau_div.sv */
// Restoring divider: one quotient bit per cycle, 64-bit dividend.
module rau_div import rau_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [WIDE_W-1:0] dividend,
   input  logic [WIDE_W-1:0] divisor,
   output logic              done,
   output logic [WIDE_W-1:0] quotient
);
   logic [WIDE_W-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [WIDE_W:0] trial;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[WIDE_W-1]} - {1'b0, d_ff};
      if (ctl.start && ctl.divide) begin
         q_in = dividend; r_in = '0; d_in = divisor; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WIDE_W]) begin
            r_in = trial[WIDE_W-1:0];
            q_in = {q_ff[WIDE_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[WIDE_W-2:0], q_ff[WIDE_W-1]};
            q_in = {q_ff[WIDE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(WIDE_W - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

/* hw/rtl/rational_arithmetic_unit_core.sv */
// Top level: rational arithmetic unit with sequencer, shared multiplier, gcd and divider.
// Sequence: an unused code or a zero divisor is answered from MUL0, a zero result from SIGN;
// otherwise setup in MUL0, MUL1, MUL2, COMB and SIGN, then the binary gcd, two divisions and a check.
// Throughput: one transaction at a time; req_stall stays high until the result has been
// taken, so the gcd step count plus both bit-serial divisions set the rate.
// Reset: synchronous, active high; returns the sequencer to idle, no result pending.
`include "rational_arithmetic_unit_core_macros.svh"
module rational_arithmetic_unit_core import rau_pkg::*; #(
   parameter int WIDTH = DEF_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_operation,
   input  logic signed [NUM_W-1:0] req_left_num,
   input  logic [DEN_W-1:0]        req_left_den,
   input  logic signed [NUM_W-1:0] req_right_num,
   input  logic [DEN_W-1:0]        req_right_den,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [NUM_W-1:0] rsp_result_num,
   output logic [DEN_W-1:0]        rsp_result_den,
   output logic                    rsp_zero_divide_error,
   output logic                    rsp_overflow
);
   localparam logic [WIDE_W-1:0] LIMIT = (WIDE_W'(1) << (WIDTH - 1)) - WIDE_W'(1);

   state_type state_ff, state_in;
   op_type op_ff;
   logic signed [WIDE_W-1:0] ln_ff, ld_ff, rn_ff, rd_ff;
   logic signed [WIDE_W-1:0] p0_ff, p1_ff, n_ff, d_ff;
   logic [WIDE_W-1:0] mag_ff, den_ff, g_ff;
   logic neg_ff;
   logic signed [WIDE_W-1:0] n_in, d_in, p0_in, p1_in;
   logic [WIDE_W-1:0] mag_in, den_in, g_in;
   logic neg_in;

   // shared multiplier: 33x33 signed, one product per cycle
   logic signed [NUM_W:0] mul_a, mul_b;
   logic signed [WIDE_W-1:0] mul_p;
   assign mul_p = WIDE_W'(mul_a * mul_b);

   logic out_v_ff, out_v_in, out_z_ff, out_z_in, out_o_ff, out_o_in;
   logic [NUM_W-1:0] out_n_ff, out_n_in;
   logic [DEN_W-1:0] out_d_ff, out_d_in;

   logic gcd_start, gcd_done, div_done;
   logic [WIDE_W-1:0] gcd_val, div_q, div_num;
   div_ctl_type div_ctl;

   // divisor must be the fresh gcd when the first division starts
   logic [WIDE_W-1:0] g_sel;
   assign g_sel = (state_ff == ST_GCD) ? gcd_val : g_ff;

   // gcd loads the magnitudes as they are formed in the sign step
   rau_gcd u_gcd (.clock, .reset, .start(gcd_start), .a_val(mag_in), .b_val(den_in),
                  .done(gcd_done), .gcd_val);
   rau_div u_div (.clock, .reset, .ctl(div_ctl), .dividend(div_num), .divisor(g_sel),
                  .done(div_done), .quotient(div_q));

   logic accept;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || out_v_ff;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; d_in = d_ff; p0_in = p0_ff; p1_in = p1_ff;
      mag_in = mag_ff; den_in = den_ff; g_in = g_ff; neg_in = neg_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_n_in = out_n_ff; out_d_in = out_d_ff; out_z_in = out_z_ff; out_o_in = out_o_ff;
      mul_a = '0; mul_b = '0;
      gcd_start = 1'b0; div_ctl = '0; div_num = mag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MUL0;
         end
         ST_MUL0: begin
            // screen error codes, then first product
            if (op_ff > OP_RED) begin
               out_v_in = 1'b1; out_n_in = '0; out_d_in = DEN_W'(1);
               out_z_in = 1'b0; out_o_in = 1'b0; state_in = ST_IDLE;
            end else if (ld_ff == 0 || (op_ff <= OP_DIV && rd_ff == 0) ||
                         (op_ff == OP_DIV && rn_ff == 0) ||
                         (op_ff == OP_INV && ln_ff == 0)) begin
               out_v_in = 1'b1; out_n_in = '0; out_d_in = DEN_W'(1);
               out_z_in = 1'b1; out_o_in = 1'b0; state_in = ST_IDLE;
            end else begin
               mul_a = (NUM_W+1)'(ln_ff);
               mul_b = (op_ff == OP_MUL) ? (NUM_W+1)'(rn_ff) : (NUM_W+1)'(rd_ff);
               p0_in = mul_p; state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            mul_a = (NUM_W+1)'(rn_ff);
            mul_b = (NUM_W+1)'(ld_ff);
            p1_in = mul_p; state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mul_a = (NUM_W+1)'(ld_ff);
            mul_b = (NUM_W+1)'(rd_ff);
            d_in = mul_p; state_in = ST_COMB;
         end
         ST_COMB: begin
            case (op_ff)
               OP_ADD: n_in = p0_ff + p1_ff;
               OP_SUB: n_in = p0_ff - p1_ff;
               OP_MUL: n_in = p0_ff;
               OP_DIV: begin n_in = p0_ff; d_in = p1_ff; end
               OP_INV: begin n_in = ld_ff; d_in = ln_ff; end
               default: begin n_in = ln_ff; d_in = ld_ff; end
            endcase
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            neg_in = n_ff[WIDE_W-1] ^ d_ff[WIDE_W-1];
            mag_in = n_ff[WIDE_W-1] ? WIDE_W'(-n_ff) : WIDE_W'(n_ff);
            den_in = d_ff[WIDE_W-1] ? WIDE_W'(-d_ff) : WIDE_W'(d_ff);
            if (n_ff == 0) begin
               out_v_in = 1'b1; out_n_in = '0; out_d_in = DEN_W'(1);
               out_z_in = 1'b0; out_o_in = 1'b0; state_in = ST_IDLE;
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (gcd_done) begin
               g_in = gcd_val;
               state_in = ST_DIVA;
            end
         end
         ST_DIVA: begin
            state_in = ST_DIVA;
            if (div_done) begin
               mag_in = div_q; state_in = ST_DIVB;
            end
         end
         ST_DIVB: begin
            div_num = den_ff;
            if (div_done) begin
               den_in = div_q; state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            out_v_in = 1'b1;
            if (mag_ff > LIMIT || den_ff > LIMIT) begin
               out_n_in = '0; out_d_in = DEN_W'(1); out_z_in = 1'b0; out_o_in = 1'b1;
            end else begin
               out_n_in = neg_ff ? NUM_W'(-mag_ff) : NUM_W'(mag_ff);
               out_d_in = DEN_W'(den_ff); out_z_in = 1'b0; out_o_in = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // launch units on entry into their states
      if (state_ff == ST_SIGN && state_in == ST_GCD) gcd_start = 1'b1;
      if (state_ff == ST_GCD && gcd_done) begin
         div_ctl.start = 1'b1; div_ctl.divide = 1'b1; div_num = mag_ff;
      end
      if (state_ff == ST_DIVA && div_done) begin
         div_ctl.start = 1'b1; div_ctl.divide = 1'b1; div_num = den_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; out_v_ff <= out_v_in;
      end
      if (accept) begin
         op_ff <= op_type'(req_operation);
         ln_ff <= WIDE_W'(req_left_num);
         ld_ff <= {{(WIDE_W-DEN_W){1'b0}}, req_left_den};
         rn_ff <= WIDE_W'(req_right_num);
         rd_ff <= {{(WIDE_W-DEN_W){1'b0}}, req_right_den};
      end
      n_ff <= n_in; d_ff <= d_in; p0_ff <= p0_in; p1_ff <= p1_in;
      mag_ff <= mag_in; den_ff <= den_in; g_ff <= g_in; neg_ff <= neg_in;
      out_n_ff <= out_n_in; out_d_ff <= out_d_in; out_z_ff <= out_z_in; out_o_ff <= out_o_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_result_num = out_n_ff;
   assign rsp_result_den = out_d_ff;
   assign rsp_zero_divide_error = out_z_ff;
   assign rsp_overflow = out_o_ff;

   `RAU_ASSERT_IMP(a_busy_stall, clock, reset, state_ff != ST_IDLE, req_stall)
   `RAU_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff == ST_MUL0)
   `RAU_ASSERT_IMP(a_err_excl, clock, reset, rsp_valid, !(rsp_zero_divide_error && rsp_overflow))
   `RAU_ASSERT_IMP(a_den_nonzero, clock, reset, rsp_valid, rsp_result_den != '0)
endmodule

/* sim/rational_arithmetic_unit_core_tb.sv */
// Testbench for the rational arithmetic unit: directed and random fractions checked against a predictor.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core_tb;
   import rau_pkg::*;

   localparam int     IDLE_LIMIT = 20000;   // cycles with no transaction before giving up
   localparam int     DRAIN_CYCLES = 400;   // covers one full pass of gcd and both divisions
   localparam longint NUM_MAX = 64'h7FFF_FFFF;

   typedef struct {
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
      logic                    zde;
      logic                    ovf;
   } fraction_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OP_W-1:0]         req_operation = '0;
   logic signed [NUM_W-1:0] req_left_num = '0;
   logic [DEN_W-1:0]        req_left_den = '0;
   logic signed [NUM_W-1:0] req_right_num = '0;
   logic [DEN_W-1:0]        req_right_den = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [NUM_W-1:0] rsp_result_num;
   logic [DEN_W-1:0]        rsp_result_den;
   logic                    rsp_zero_divide_error;
   logic                    rsp_overflow;

   // Expected reduced fractions, oldest first.
   fraction_result_type pending_fractions[$];
   int sent_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int hold_off_request = 0;   // long receiver hold-off, consumed by the receiver process
   int hold_off_left = 0;
   int quiet_cycles = 0;

   always #2 clock = ~clock;

   rational_arithmetic_unit_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation),
      .req_left_num(req_left_num), .req_left_den(req_left_den),
      .req_right_num(req_right_num), .req_right_den(req_right_den),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_num(rsp_result_num), .rsp_result_den(rsp_result_den),
      .rsp_zero_divide_error(rsp_zero_divide_error), .rsp_overflow(rsp_overflow)
   );

   // Compute the exact rational result, reduced to lowest terms.
   function automatic fraction_result_type reduce_fraction_op(
         input logic [OP_W-1:0] op, input logic signed [NUM_W-1:0] lnum,
         input logic [DEN_W-1:0] lden, input logic signed [NUM_W-1:0] rnum,
         input logic [DEN_W-1:0] rden);
      fraction_result_type r;
      longint ln, ld, rn, rd, n, d;
      longint unsigned mag, den, a, b, t;
      bit neg;
      r = '{num: '0, den: 1, zde: 1'b0, ovf: 1'b0};
      ln = lnum;
      rn = rnum;
      ld = longint'({1'b0, lden});
      rd = longint'({1'b0, rden});
      if (op > OP_RED) return r;
      if (ld == 0 || (op <= OP_DIV && rd == 0)) begin
         r.zde = 1'b1;
         return r;
      end
      case (op)
         OP_ADD: begin n = ln * rd + rn * ld; d = ld * rd; end
         OP_SUB: begin n = ln * rd - rn * ld; d = ld * rd; end
         OP_MUL: begin n = ln * rn; d = ld * rd; end
         OP_DIV: begin
            if (rn == 0) begin
               r.zde = 1'b1;
               return r;
            end
            n = ln * rd; d = rn * ld;
         end
         OP_INV: begin
            if (ln == 0) begin
               r.zde = 1'b1;
               return r;
            end
            n = ld; d = ln;
         end
         default: begin n = ln; d = ld; end
      endcase
      neg = (n < 0) != (d < 0);
      mag = (n < 0) ? -n : n;
      den = (d < 0) ? -d : d;
      if (mag == 0) return r;
      a = mag;
      b = den;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      mag = mag / a;
      den = den / a;
      if (mag > NUM_MAX || den > NUM_MAX) begin
         r.ovf = 1'b1;
         return r;
      end
      r.num = neg ? -mag[NUM_W-1:0] : mag[NUM_W-1:0];
      r.den = den[DEN_W-1:0];
      return r;
   endfunction

   // Offer one transaction, idling first at random; record the prediction on acceptance.
   task automatic send_fraction_op(input logic [OP_W-1:0] op,
         input logic signed [NUM_W-1:0] lnum, input logic [DEN_W-1:0] lden,
         input logic signed [NUM_W-1:0] rnum, input logic [DEN_W-1:0] rden);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_left_num <= lnum;
      req_left_den <= lden;
      req_right_num <= rnum;
      req_right_den <= rden;
      do @(posedge clock); while (req_stall);
      pending_fractions.push_back(reduce_fraction_op(op, lnum, lden, rnum, rden));
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_fractions.size() != 0) @(posedge clock);
   endtask

   // Receiver: check each accepted result, then pick next cycle's stall.
   always @(posedge clock) begin
      fraction_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (pending_fractions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result %0d/%0d", rsp_result_num, rsp_result_den);
         end else begin
            exp_r = pending_fractions.pop_front();
            if (rsp_result_num !== exp_r.num || rsp_result_den !== exp_r.den ||
                  rsp_zero_divide_error !== exp_r.zde || rsp_overflow !== exp_r.ovf) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: expected %0d/%0d zde=%b ovf=%b, got %0d/%0d zde=%b ovf=%b",
                     exp_r.num, exp_r.den, exp_r.zde, exp_r.ovf, rsp_result_num,
                     rsp_result_den, rsp_zero_divide_error, rsp_overflow);
            end
         end
      end
      if (hold_off_request != 0) begin
         hold_off_left = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Extremes, every operation, zero divisors, zero denominators, unused codes, overflow.
   task automatic test_directed();
      logic signed [NUM_W-1:0] nmin, nmax;
      logic [DEN_W-1:0] dmax;
      nmin = 32'sh8000_0000;
      nmax = 32'sh7FFF_FFFF;
      dmax = '1;
      send_fraction_op(OP_ADD, 1, 2, 1, 3);
      send_fraction_op(OP_ADD, 1, 2, -1, 2);           // zero result
      send_fraction_op(OP_SUB, nmax, dmax, nmin, 1);
      send_fraction_op(OP_SUB, 5, 6, 1, 6);
      send_fraction_op(OP_MUL, nmax, 1, 2, 1);         // overflow
      send_fraction_op(OP_MUL, nmin, 3, -1, 2);
      send_fraction_op(OP_MUL, nmin, dmax, nmin, dmax);
      send_fraction_op(OP_DIV, 3, 4, 0, 5);            // divide by zero
      send_fraction_op(OP_DIV, -3, 4, -9, 8);
      send_fraction_op(OP_DIV, nmin, 1, -2, 1);
      send_fraction_op(OP_INV, 0, 7, 1, 1);            // invert zero
      send_fraction_op(OP_INV, -6, 4, 0, 0);
      send_fraction_op(OP_INV, nmin, 1, 0, 0);         // denominator 2^31 overflows
      send_fraction_op(OP_RED, -12, 18, 0, 0);
      send_fraction_op(OP_RED, nmin, 2, 0, 0);
      send_fraction_op(OP_RED, nmax, dmax, nmax, dmax);
      send_fraction_op(OP_ADD, 1, 0, 1, 1);            // zero left denominator
      send_fraction_op(OP_MUL, 1, 1, 1, 0);            // zero right denominator
      send_fraction_op(OP_INV, 2, 1, 1, 0);            // right ignored
      send_fraction_op(3'd6, 5, 5, 5, 5);
      send_fraction_op(3'd7, nmin, dmax, nmax, dmax);
      send_fraction_op(OP_ADD, nmin, 1, nmin, 1);      // sum beyond range
      wait_drained();
   endtask

   function automatic logic signed [NUM_W-1:0] pick_num(input int kind);
      case (kind)
         0: return $signed(32'($urandom_range(200))) - 100;
         1: return $signed($urandom());
         default: return ($urandom_range(1)) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      endcase
   endfunction

   function automatic logic [DEN_W-1:0] pick_den(input int kind);
      case (kind)
         0: return 31'($urandom_range(100, 1));
         1: return ($urandom_range(49) == 0) ? 31'd0 : 31'($urandom());
         default: return ($urandom_range(1)) ? 31'h7FFF_FFFF : 31'd1;
      endcase
   endfunction

   task automatic test_random(input int count);
      int kind;
      int scale;
      logic [OP_W-1:0] op;
      logic signed [NUM_W-1:0] ln, rn;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(9) < 5 ? 0 : ($urandom_range(9) < 8 ? 1 : 2);
         op = ($urandom_range(39) == 0) ? OP_W'($urandom_range(7, 6))
                                        : OP_W'($urandom_range(5));
         ln = pick_num(kind);
         rn = pick_num(kind);
         // scale small operands by a shared factor so cancellation happens often
         scale = $urandom_range(12, 1);
         if (kind == 0) begin
            ln = ln * scale;
            rn = rn * scale;
         end
         send_fraction_op(op, ln, pick_den(kind), rn, pick_den(kind));
      end
   endtask

   // Hold the receiver off while the sender keeps offering, then pause until drained.
   task automatic test_backpressure();
      hold_off_request = 900;
      for (int i = 0; i < 8; i++)
         send_fraction_op(OP_ADD, pick_num(0), pick_den(0), pick_num(1), pick_den(1));
      wait_drained();
      for (int i = 0; i < 6; i++)
         send_fraction_op(OP_DIV, pick_num(1), pick_den(1), pick_num(0), pick_den(0));
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      sender_idle_pct = 33;
      receiver_idle_pct = 81;
      test_random(400);
      sender_idle_pct = 81;
      receiver_idle_pct = 33;
      test_random(400);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_backpressure();
      test_random(420);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d fraction operations (all codes, extremes, zero divisors, overflow)",
         sent_count);
      $display("under both idle mixes and a long hold-off; %0d results checked, %0d wrong",
         checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_fractions.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
